// ===== rtl/smpd_pkg.sv =====
// Shared types and constants for the serial mouse packet decoder.
// Used by smpd_ctrl, smpd_datapath and serial_mouse_packet_decoder_top.
package smpd_pkg;

   localparam int BYTE_W  = 8;
   localparam int WIN_W   = 16;
   localparam int DELTA_W = 8;
   localparam int CSR_IDX_W = 3;

   // packet byte layout
   localparam int START_BIT = 6;
   localparam int LEFT_BIT  = 5;
   localparam int RIGHT_BIT = 4;
   localparam logic [BYTE_W-1:0] HI_X_MASK = 8'h03;
   localparam logic [BYTE_W-1:0] HI_Y_MASK = 8'h0C;
   localparam logic [BYTE_W-1:0] LOW6_MASK = 8'd63;

   // divider: one quotient bit per step
   localparam int DIV_BITS  = 8;
   localparam int DIV_CNT_W = $clog2(DIV_BITS);

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_DIVISOR = 3'd0,
      CSR_Y_DIVISOR = 3'd1,
      CSR_X_MIN     = 3'd2,
      CSR_X_MAX     = 3'd3,
      CSR_Y_MIN     = 3'd4,
      CSR_Y_MAX     = 3'd5
   } csr_index_type;

   localparam logic [BYTE_W-1:0]       X_DIVISOR_RST = 8'd3;
   localparam logic [BYTE_W-1:0]       Y_DIVISOR_RST = 8'd3;
   localparam logic signed [WIN_W-1:0] X_MIN_RST = 16'sd0;
   localparam logic signed [WIN_W-1:0] X_MAX_RST = 16'sd79;
   localparam logic signed [WIN_W-1:0] Y_MIN_RST = 16'sd0;
   localparam logic signed [WIN_W-1:0] Y_MAX_RST = 16'sd24;

   typedef struct packed {
      logic capture;       // take the request byte
      logic div_load;      // load divider with a delta
      logic div_axis_y;    // divider operand: 0 = X, 1 = Y
      logic div_step;      // one quotient bit
      logic apply;         // add quotient to position and clamp
      logic apply_axis_y;  // position to update: 0 = X, 1 = Y
      logic load_out;      // load response registers
   } cmd_type;

   typedef struct packed {
      logic complete;      // request byte closes a packet
      logic div_last;      // divider is on its final step
   } status_type;

endpackage

// ===== rtl/smpd_ctrl.sv =====
// Sequencer for the serial mouse packet decoder: handshakes and datapath commands.
// Depends on smpd_pkg.
module smpd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  smpd_pkg::status_type  status,
   output smpd_pkg::cmd_type     cmd
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LDX  = 7'b0000010,
      S_DIVX = 7'b0000100,
      S_ADDX = 7'b0001000,
      S_DIVY = 7'b0010000,
      S_ADDY = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd              = '0;
      state_in         = state_ff;
      cmd.div_axis_y   = (state_ff == S_ADDX);
      cmd.apply_axis_y = (state_ff == S_ADDY);
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid && status.complete) begin
               state_in = S_LDX;
            end
         end
         S_LDX: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIVX;
         end
         S_DIVX: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_ADDX;
            end
         end
         S_ADDX: begin
            // update X and start the Y divide together
            cmd.apply    = 1'b1;
            cmd.div_load = 1'b1;
            state_in     = S_DIVY;
         end
         S_DIVY: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_ADDY;
            end
         end
         S_ADDY: begin
            cmd.apply = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            // hold until the previous response is gone
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/smpd_datapath.sv =====
// Datapath for the serial mouse packet decoder: packet assembly, config registers,
// shared restoring divider, position update with clamp, response registers. Uses smpd_pkg.
module smpd_datapath #(
   parameter int POS_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smpd_pkg::cmd_type                     cmd,
   output smpd_pkg::status_type                  status,
   input  logic [smpd_pkg::BYTE_W-1:0]           req_rx_byte,
   input  logic                                  csr_we,
   input  logic [smpd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [smpd_pkg::WIN_W-1:0]            csr_wdata,
   output logic signed [POS_WIDTH-1:0]           rsp_pos_x,
   output logic signed [POS_WIDTH-1:0]           rsp_pos_y,
   output logic signed [smpd_pkg::DELTA_W-1:0]   rsp_delta_x,
   output logic signed [smpd_pkg::DELTA_W-1:0]   rsp_delta_y,
   output logic                                  rsp_left_button,
   output logic                                  rsp_right_button
);

   localparam int BW = smpd_pkg::BYTE_W;
   localparam int WW = smpd_pkg::WIN_W;
   localparam int DW = smpd_pkg::DELTA_W;
   localparam int CW = ((POS_WIDTH > WW) ? POS_WIDTH : WW) + 2;
   localparam logic signed [CW-1:0] PMAX = CW'((longint'(1) <<< (POS_WIDTH - 1)) - 1);
   localparam logic signed [CW-1:0] PMIN = -PMAX - CW'(1);

   // configuration
   logic [BW-1:0]        x_div_ff, y_div_ff;
   logic signed [WW-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_div_ff <= smpd_pkg::X_DIVISOR_RST;
         y_div_ff <= smpd_pkg::Y_DIVISOR_RST;
         x_min_ff <= smpd_pkg::X_MIN_RST;
         x_max_ff <= smpd_pkg::X_MAX_RST;
         y_min_ff <= smpd_pkg::Y_MIN_RST;
         y_max_ff <= smpd_pkg::Y_MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            smpd_pkg::CSR_X_DIVISOR: x_div_ff <= csr_wdata[BW-1:0];
            smpd_pkg::CSR_Y_DIVISOR: y_div_ff <= csr_wdata[BW-1:0];
            smpd_pkg::CSR_X_MIN:     x_min_ff <= csr_wdata;
            smpd_pkg::CSR_X_MAX:     x_max_ff <= csr_wdata;
            smpd_pkg::CSR_Y_MIN:     y_min_ff <= csr_wdata;
            smpd_pkg::CSR_Y_MAX:     y_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic [5:0] req_byte_low6(input logic [BW-1:0] b);
      logic [BW-1:0] m;
      m = b & smpd_pkg::LOW6_MASK;
      return m[5:0];
   endfunction

   // packet assembly
   logic [1:0]           idx_ff, idx_in, idx_eff;
   logic [BW-1:0]        pkt0_ff, pkt1_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic                 left_ff, right_ff;

   assign idx_eff = req_rx_byte[smpd_pkg::START_BIT] ? 2'd0 : idx_ff;
   assign status.complete = idx_eff[1];
   assign dx_in = {pkt0_ff[1:0] & smpd_pkg::HI_X_MASK[1:0],
                   req_byte_low6(pkt1_ff)};
   assign dy_in = {pkt0_ff[3:2] & smpd_pkg::HI_Y_MASK[3:2],
                   req_byte_low6(req_rx_byte)};
   assign idx_in = status.complete ? 2'd0 : (idx_eff + 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else if (cmd.capture) begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if (!status.complete) begin
            if (idx_eff[0]) begin
               pkt1_ff <= req_rx_byte;
            end else begin
               pkt0_ff <= req_rx_byte;
            end
         end else begin
            dx_ff    <= dx_in;
            dy_ff    <= dy_in;
            left_ff  <= pkt0_ff[smpd_pkg::LEFT_BIT];
            right_ff <= pkt0_ff[smpd_pkg::RIGHT_BIT];
         end
      end
   end

   // restoring divider on the delta magnitude
   logic [BW-1:0]                  q_ff, rem_ff, d_ff;
   logic                           neg_ff;
   logic [smpd_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic signed [DW-1:0]           d_sel;
   logic [BW-1:0]                  div_sel, mag;
   logic [BW:0]                    trial;
   logic                           fits;

   assign d_sel   = cmd.div_axis_y ? dy_ff : dx_ff;
   assign div_sel = cmd.div_axis_y ? y_div_ff : x_div_ff;
   assign mag     = d_sel[DW-1] ? (~BW'(d_sel) + BW'(1)) : BW'(d_sel);
   assign trial   = {rem_ff, q_ff[BW-1]};
   assign fits    = (trial >= {1'b0, d_ff});
   assign status.div_last = (cnt_ff == smpd_pkg::DIV_CNT_W'(smpd_pkg::DIV_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_load) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + smpd_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         q_ff   <= mag;
         rem_ff <= '0;
         d_ff   <= (div_sel == '0) ? BW'(1) : div_sel;  // zero divisor acts as one
         neg_ff <= d_sel[DW-1];
      end else if (cmd.div_step) begin
         rem_ff <= fits ? BW'(trial - {1'b0, d_ff}) : trial[BW-1:0];
         q_ff   <= {q_ff[BW-2:0], fits};
      end
   end

   // position update: add, clamp to window, saturate to position range
   logic signed [POS_WIDTH-1:0] cur_x_ff, cur_y_ff, cur_sel, cur_in;
   logic signed [BW:0]          q_mag, q_signed;
   logic signed [CW-1:0]        sum_w, lo_w, hi_w, win_w, sat_w;

   assign cur_sel  = cmd.apply_axis_y ? cur_y_ff : cur_x_ff;
   assign q_mag    = {1'b0, q_ff};
   assign q_signed = neg_ff ? (~q_mag + (BW+1)'(1)) : q_mag;
   assign lo_w     = cmd.apply_axis_y ? CW'(y_min_ff) : CW'(x_min_ff);
   assign hi_w     = cmd.apply_axis_y ? CW'(y_max_ff) : CW'(x_max_ff);
   assign sum_w    = CW'(cur_sel) + CW'(q_signed);

   always_comb begin
      // below min wins over above max when the window is inverted
      if (sum_w < lo_w) begin
         win_w = lo_w;
      end else if (sum_w > hi_w) begin
         win_w = hi_w;
      end else begin
         win_w = sum_w;
      end
      if (win_w > PMAX) begin
         sat_w = PMAX;
      end else if (win_w < PMIN) begin
         sat_w = PMIN;
      end else begin
         sat_w = win_w;
      end
      cur_in = sat_w[POS_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else if (cmd.apply) begin
         if (cmd.apply_axis_y) begin
            cur_y_ff <= cur_in;
         end else begin
            cur_x_ff <= cur_in;
         end
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_pos_x        <= cur_x_ff;
         rsp_pos_y        <= cur_y_ff;
         rsp_delta_x      <= dx_ff;
         rsp_delta_y      <= dy_ff;
         rsp_left_button  <= left_ff;
         rsp_right_button <= right_ff;
      end
   end

endmodule

// ===== rtl/serial_mouse_packet_decoder_top.sv =====
// Top level of the serial mouse packet decoder: sequencer plus datapath.
// Depends on smpd_pkg, smpd_ctrl and smpd_datapath.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_rx_byte
//   rsp_      out        rsp_valid/rsp_stall   rsp_pos_x/y, rsp_delta_x/y, buttons
//   csr_      in         csr_we                csr_index, csr_wdata
//
// The first and second bytes of a packet are each taken in the idle state. A closing byte
// runs two 8-step passes of the one shared bit-serial divider (X, then Y),
// plus load, two position updates and the response load.
// Reset is synchronous; it restores the registers and clears position and index.
// A stalled response holds only the final load; earlier bytes keep flowing.
module serial_mouse_packet_decoder_top #(
   parameter int POS_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [smpd_pkg::BYTE_W-1:0]           req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [POS_WIDTH-1:0]           rsp_pos_x,
   output logic signed [POS_WIDTH-1:0]           rsp_pos_y,
   output logic signed [smpd_pkg::DELTA_W-1:0]   rsp_delta_x,
   output logic signed [smpd_pkg::DELTA_W-1:0]   rsp_delta_y,
   output logic                                  rsp_left_button,
   output logic                                  rsp_right_button,
   input  logic                                  csr_we,
   input  logic [smpd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [smpd_pkg::WIN_W-1:0]            csr_wdata
);

   smpd_pkg::cmd_type    cmd;
   smpd_pkg::status_type status;

   smpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   smpd_datapath #(
      .POS_WIDTH (POS_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_rx_byte      (req_rx_byte),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_delta_x      (rsp_delta_x),
      .rsp_delta_y      (rsp_delta_y),
      .rsp_left_button  (rsp_left_button),
      .rsp_right_button (rsp_right_button)
   );

   // never overwrite a response that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid && rsp_stall))
      else $error("response loaded over a pending one");

   // the last divide step hands over to a position update
   a_div_then_apply: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=> cmd.apply)
      else $error("position update did not follow the divide");

   // a closing byte makes the block busy
   a_busy_after_packet: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && status.complete) |=> req_stall)
      else $error("request taken while a packet is in work");

endmodule
